// File: rtl/pfcw_pkg.sv
// ----------------------------------------------------------------------------
// pfcw_pkg
// Shared constants and types for the page framebuffer column writer.
// ----------------------------------------------------------------------------
package pfcw_pkg;

    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int PANEL_ROWS = PAGES * 8;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(PANEL_ROWS);
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// File: rtl/page_framebuffer_column_writer.sv
// ----------------------------------------------------------------------------
// page_framebuffer_column_writer
// Page-organized monochrome frame store with column writes, clear and reads.
// ----------------------------------------------------------------------------
// An accepted item waits in ST_EXEC until the output register is free, and
// the result register loads then. New input is accepted only in ST_IDLE, so
// a new item is not taken before the last result is loaded. The column
// store is read in the accept cycle and written back on completion.
// Reset: aresetn (synchronous, active low) empties the output register and
// marks every column invalid, so the store reads as all zero at once.
module page_framebuffer_column_writer
    import pfcw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] x, [15:8] y, [23:16] bits, [27:24] rows, [30:28] read_page,
    // [37:31] read_column, [39:38] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]     s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] read_data, [8] clipped, [15:9] zero
    output logic [M_DATA_W-1:0] m_tdata
);

    // One memory word per column holds every page of that column, so a
    // write that spans two pages is still one read-modify-write.
    logic [PANEL_ROWS-1:0] store_mem [COLUMNS];
    logic [COLUMNS-1:0]    col_valid_reg;

    state_t state_reg, state_next;

    // Unpack the input transaction.
    logic [7:0] x_in, y_in, bits_in;
    logic [3:0] rows_in;
    logic [2:0] rpage_in;
    logic [6:0] rcol_in;

    assign x_in     = s_tdata[7:0];
    assign y_in     = s_tdata[15:8];
    assign bits_in  = s_tdata[23:16];
    assign rows_in  = s_tdata[27:24];
    assign rpage_in = s_tdata[30:28];
    assign rcol_in  = s_tdata[37:31];

    // Held item fields and the word read for it.
    logic [OP_W-1:0]       op_reg;
    logic [7:0]            x_reg, y_reg, bits_reg;
    logic [3:0]            rows_reg;
    logic [2:0]            rpage_reg;
    logic [6:0]            rcol_reg;
    logic [PANEL_ROWS-1:0] rd_word_reg;
    logic                  rd_valid_reg;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_clip_reg;

    logic             s_accept;
    logic             exec_fire;
    logic             out_free;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] wr_addr;
    logic             wr_en;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Reads address by read_column, everything else by x.
    assign rd_addr = (s_tuser == OP_READ) ? COL_W'(rcol_in) : COL_W'(x_in);
    assign wr_addr = COL_W'(x_reg);

    // Next state and handshake.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Hold the item until the output register can take the result.
                if (out_free) begin
                    exec_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Build the bit mask and values of a column write, and the clip flag.
    logic [PANEL_ROWS-1:0] old_word;
    logic [PANEL_ROWS-1:0] wr_mask;
    logic [PANEL_ROWS-1:0] wr_vals;
    logic [PANEL_ROWS-1:0] new_word;
    logic                  x_ok;
    logic                  clip_any;

    assign old_word = rd_valid_reg ? rd_word_reg : '0;
    assign x_ok     = {1'b0, x_reg} < 9'(COLUMNS);

    always_comb begin
        logic [7:0] row;
        wr_mask  = '0;
        wr_vals  = '0;
        clip_any = 1'b0;
        for (int j = 0; j < 8; j++) begin
            row = y_reg + 8'(j);  // row wraps modulo 256
            if (4'(j) < rows_reg) begin
                if (x_ok && ({1'b0, row} < 9'(PANEL_ROWS))) begin
                    wr_mask[ROW_W'(row)] = 1'b1;
                    wr_vals[ROW_W'(row)] = bits_reg[j];
                end else begin
                    clip_any = 1'b1;
                end
            end
        end
    end

    assign new_word = (old_word & ~wr_mask) | (wr_vals & wr_mask);
    assign wr_en    = exec_fire && (op_reg == OP_WRITE) && x_ok;

    // Select the requested page byte; out-of-range reads return zero.
    logic [7:0] rd_byte;
    logic       rd_ok;

    assign rd_ok = ({2'b00, rcol_reg} < 9'(COLUMNS)) && ({3'b000, rpage_reg} < 6'(PAGES));

    always_comb begin
        rd_byte = '0;
        for (int p = 0; p < PAGES; p++) begin
            if (6'(p) == {3'b000, rpage_reg}) begin
                rd_byte = old_word[p*8 +: 8];
            end
        end
    end

    // Column store: read on accept, write back on completion.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= new_word;
        end
        if (s_accept) begin
            rd_word_reg <= store_mem[rd_addr];
        end
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg       <= s_tuser;
            x_reg        <= x_in;
            y_reg        <= y_in;
            bits_reg     <= bits_in;
            rows_reg     <= rows_in;
            rpage_reg    <= rpage_in;
            rcol_reg     <= rcol_in;
            rd_valid_reg <= col_valid_reg[rd_addr];
        end
    end

    // Control: state, column valid bits, output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Clear drops every column at once; a write marks its column.
            if (exec_fire && (op_reg == OP_CLEAR)) begin
                col_valid_reg <= '0;
            end else if (wr_en) begin
                col_valid_reg[wr_addr] <= 1'b1;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_data_reg <= ((op_reg == OP_READ) && rd_ok) ? rd_byte : 8'd0;
            m_clip_reg <= (op_reg == OP_WRITE) ? clip_any : 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_clip_reg, m_data_reg};

endmodule
